// ===== hdl/jsv_pkg.sv =====
// ----------------------------------------------------------------------------
// jsv_pkg
// Types, codes and lookup functions shared by the JSON syntax validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

   typedef enum logic [3:0] {
      LX_IDLE, LX_STR, LX_ESC, LX_HEX, LX_NULL, LX_TRUE, LX_FALSE,
      NM_MINUS, NM_ZERO, NM_INT, NM_DOT, NM_FRAC, NM_E, NM_ESIGN, NM_EXP
   } lex_type;

   typedef enum logic [2:0] {
      GR_VALUE, GR_VALUE_OR_CLOSE, GR_KEY_OR_CLOSE, GR_KEY, GR_COLON, GR_AFTER, GR_DONE
   } gr_type;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_TOKEN   = 3'd1;
   localparam logic [2:0] ERR_ESCAPE  = 3'd2;
   localparam logic [2:0] ERR_NUMBER  = 3'd3;
   localparam logic [2:0] ERR_GRAMMAR = 3'd4;
   localparam logic [2:0] ERR_DEEP    = 3'd5;
   localparam logic [2:0] ERR_TRUNC   = 3'd6;

   localparam int          DEPTH_W         = 10;
   localparam int          OFFSET_W        = 24;
   localparam logic [9:0]  MAX_DEPTH_RESET = 10'd1000;

   // one character word plus its class flags
   typedef struct packed {
      logic [15:0] ch;
      logic        last;
      logic        is_ws;
      logic        is_digit;
      logic        is_hex;
   } item_type;

   typedef struct packed {
      logic                valid_res;
      logic [2:0]          error_code;
      logic [OFFSET_W-1:0] error_offset;
   } result_type;

   // expected character of a literal at index idx, zero past its end
   function automatic logic [15:0] lit_char(input lex_type kind, input logic [2:0] idx);
      logic [7:0] a;
      a = 8'h00;
      case (kind)
         LX_NULL: begin
            case (idx)
               3'd0: a = "n";
               3'd1: a = "u";
               3'd2: a = "l";
               3'd3: a = "l";
               default: a = 8'h00;
            endcase
         end
         LX_TRUE: begin
            case (idx)
               3'd0: a = "t";
               3'd1: a = "r";
               3'd2: a = "u";
               3'd3: a = "e";
               default: a = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0: a = "f";
               3'd1: a = "a";
               3'd2: a = "l";
               3'd3: a = "s";
               3'd4: a = "e";
               default: a = 8'h00;
            endcase
         end
      endcase
      return {8'h00, a};
   endfunction

endpackage

// ===== hdl/jsv_if.sv =====
// ----------------------------------------------------------------------------
// jsv interfaces
// Valid/ready channels for characters, verdicts and the depth register.
// ----------------------------------------------------------------------------
interface jsv_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] ch;
   logic        last;
   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface jsv_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [2:0]  error_code;
   logic [23:0] error_offset;
   modport source (output valid, output valid_res, output error_code,
                   output error_offset, input ready);
   modport sink (input valid, input valid_res, input error_code,
                 input error_offset, output ready);
endinterface

interface jsv_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/jsv_front.sv =====
// ----------------------------------------------------------------------------
// jsv_front
// Accepts characters, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module jsv_front
   import jsv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   jsv_req_if.sink  req_bus,
   output logic     item_valid,
   output item_type item,
   input  logic     item_pop
);

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push;

   always_comb begin
      cls.ch       = req_bus.ch;
      cls.last     = req_bus.last;
      cls.is_ws    = (req_bus.ch == 16'h0020) ||
                     (req_bus.ch >= 16'h0009 && req_bus.ch <= 16'h000D);
      cls.is_digit = req_bus.ch >= 16'h0030 && req_bus.ch <= 16'h0039;
      cls.is_hex   = cls.is_digit ||
                     (req_bus.ch >= 16'h0061 && req_bus.ch <= 16'h0066) ||
                     (req_bus.ch >= 16'h0041 && req_bus.ch <= 16'h0046);
   end

   assign req_bus.ready = cnt_ff != 2'd2;
   assign push          = req_bus.valid && req_bus.ready;
   assign item_valid    = cnt_ff != 2'd0;
   assign item          = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = item_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

endmodule

// ===== hdl/jsv_back.sv =====
// ----------------------------------------------------------------------------
// jsv_back
// Lexer, grammar tracker, container stack and verdict register.
// ----------------------------------------------------------------------------
module jsv_back
   import jsv_pkg::*;
#(
   parameter int STACK_DEPTH   = 1024,
   parameter int POSITION_BITS = 24
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   jsv_csr_if.sink  csr_bus,
   jsv_rsp_if.source rsp_bus
);

   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   lex_type                  lex_ff, lex_in;
   gr_type                   gr_ff, gr_in;
   logic [LVL_W-1:0]         lvl_ff, lvl_in;
   logic [2:0]               sub_ff, sub_in;
   logic [2:0]               ferr_ff, ferr_in;
   logic [POSITION_BITS-1:0] epos_ff, epos_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     top_ff, top_in;
   logic                     below_ff;
   logic [DEPTH_W-1:0]       max_depth_ff;
   result_type               res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     stack_mem [STACK_DEPTH];
   logic                     push, push_kind, pop;
   logic [ADDR_W-1:0]        waddr, raddr;
   logic                     can_out, fire;

   assign can_out  = !rsp_valid_ff || rsp_bus.ready;
   assign fire     = item_valid && (!item.last || can_out);
   assign item_pop = fire;

   always_comb begin
      lex_type                  lx;
      gr_type                   gr;
      logic [LVL_W-1:0]         lvl;
      logic [2:0]               sub;
      logic [2:0]               ne;
      logic [POSITION_BITS-1:0] pnext;
      logic [7:0]               a;
      logic                     d, ex, taken, vpos, tok, vstart;

      lx = lex_ff; gr = gr_ff; lvl = lvl_ff; sub = sub_ff;
      ne = ERR_NONE; taken = 1'b0;
      push = 1'b0; push_kind = 1'b0; pop = 1'b0;
      a  = (item.ch[15:8] == 8'h00) ? item.ch[7:0] : 8'h00;
      d  = item.is_digit;
      ex = a == "e" || a == "E";
      vstart = a == "n" || a == "t" || a == "f" || a == "-" || d ||
               a == "\"" || a == "[" || a == "{";
      tok = vstart || a == "]" || a == "}" || a == "," || a == ":";
      vpos = 1'b0;
      pnext = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : pos_ff;

      ferr_in = ferr_ff; epos_in = epos_ff;
      res_in = res_ff;

      if (ferr_ff == ERR_NONE) begin
         if (lx >= NM_MINUS) begin
            taken = 1'b1;
            case (lx)
               NM_MINUS: begin
                  if (a == "0") lx = NM_ZERO;
                  else if (d) lx = NM_INT;
                  else ne = ERR_NUMBER;
               end
               NM_ZERO, NM_INT: begin
                  if (d) begin
                     if (lx == NM_ZERO) ne = ERR_NUMBER;
                  end else if (a == ".") lx = NM_DOT;
                  else if (ex) lx = NM_E;
                  else taken = 1'b0;
               end
               NM_DOT: begin
                  if (d) lx = NM_FRAC;
                  else ne = ERR_NUMBER;
               end
               NM_FRAC: begin
                  if (d) taken = 1'b1;
                  else if (ex) lx = NM_E;
                  else taken = 1'b0;
               end
               NM_E: begin
                  if (a == "+" || a == "-") lx = NM_ESIGN;
                  else if (d) lx = NM_EXP;
                  else ne = ERR_NUMBER;
               end
               NM_ESIGN: begin
                  if (d) lx = NM_EXP;
                  else ne = ERR_NUMBER;
               end
               default: taken = d;
            endcase
            if (!taken) begin
               lx = LX_IDLE;
               gr = (lvl == '0) ? GR_DONE : GR_AFTER;
            end
         end
         if (!taken) begin
            case (lx)
               LX_IDLE: begin
                  vpos = gr == GR_VALUE || gr == GR_VALUE_OR_CLOSE;
                  if (item.is_ws) begin
                     if (gr == GR_DONE) ne = ERR_TRUNC;
                  end else if (gr == GR_DONE) begin
                     ne = ERR_TRUNC;
                  end else if ((gr == GR_VALUE_OR_CLOSE && a == "]") ||
                               (gr == GR_KEY_OR_CLOSE && a == "}")) begin
                     pop = 1'b1;
                  end else if (vpos && 32'(lvl) > 32'(max_depth_ff)) begin
                     ne = ERR_DEEP;
                  end else if (!tok) begin
                     ne = ERR_TOKEN;
                  end else begin
                     case (gr)
                        GR_VALUE, GR_VALUE_OR_CLOSE: begin
                           if (!vstart) ne = ERR_GRAMMAR;
                           else if (a == "[" || a == "{") begin
                              if (32'(lvl) >= STACK_DEPTH) ne = ERR_DEEP;
                              else begin
                                 push      = 1'b1;
                                 push_kind = a == "{";
                                 gr = push_kind ? GR_KEY_OR_CLOSE : GR_VALUE_OR_CLOSE;
                              end
                           end
                           else if (a == "\"") lx = LX_STR;
                           else if (a == "n") begin lx = LX_NULL; sub = 3'd1; end
                           else if (a == "t") begin lx = LX_TRUE; sub = 3'd1; end
                           else if (a == "f") begin lx = LX_FALSE; sub = 3'd1; end
                           else if (a == "-") lx = NM_MINUS;
                           else if (a == "0") lx = NM_ZERO;
                           else lx = NM_INT;
                        end
                        GR_KEY_OR_CLOSE, GR_KEY: begin
                           if (a == "\"") begin lx = LX_STR; gr = GR_COLON; end
                           else ne = ERR_GRAMMAR;
                        end
                        GR_COLON: begin
                           if (a == ":") gr = GR_VALUE;
                           else ne = ERR_GRAMMAR;
                        end
                        default: begin
                           if (a == ",") gr = top_ff ? GR_KEY : GR_VALUE;
                           else if ((a == "]" && !top_ff) || (a == "}" && top_ff)) pop = 1'b1;
                           else ne = ERR_GRAMMAR;
                        end
                     endcase
                  end
                  if (pop) begin
                     lvl = lvl - 1'b1;
                     gr  = (lvl == '0) ? GR_DONE : GR_AFTER;
                  end
                  if (push) lvl = lvl + 1'b1;
               end
               LX_STR: begin
                  if (a == "\\") lx = LX_ESC;
                  else if (a == "\"") begin
                     lx = LX_IDLE;
                     if (gr != GR_COLON) gr = (lvl == '0) ? GR_DONE : GR_AFTER;
                  end
               end
               LX_ESC: begin
                  if (a == "x") begin lx = LX_HEX; sub = 3'd2; end
                  else if (a == "u") begin lx = LX_HEX; sub = 3'd4; end
                  else if (a == "\\" || a == "/" || a == "b" || a == "f" || a == "n" ||
                           a == "r" || a == "t" || a == "v" || a == "\"") lx = LX_STR;
                  else ne = ERR_ESCAPE;
               end
               LX_HEX: begin
                  if (!item.is_hex) ne = ERR_ESCAPE;
                  else begin
                     if (sub != 3'd0) sub = sub - 3'd1;
                     if (sub == 3'd0) lx = LX_STR;
                  end
               end
               default: begin
                  if (sub > 3'd4 || item.ch != lit_char(lx, sub)) ne = ERR_TOKEN;
                  else begin
                     sub = sub + 3'd1;
                     if (sub > 3'd4 || lit_char(lx, sub) == 16'h0000) begin
                        lx  = LX_IDLE;
                        sub = 3'd0;
                        gr  = (lvl == '0) ? GR_DONE : GR_AFTER;
                     end
                  end
               end
            endcase
         end
         if (ne != ERR_NONE) begin
            ferr_in = ne;
            epos_in = pos_ff;
         end
      end

      if (item.last) begin
         if (ferr_in == ERR_NONE) begin
            if (lx == NM_ZERO || lx == NM_INT || lx == NM_FRAC || lx == NM_EXP) begin
               lx = LX_IDLE;
               gr = (lvl == '0) ? GR_DONE : GR_AFTER;
            end
            if (lx != LX_IDLE || gr != GR_DONE) begin
               ferr_in = ERR_TRUNC;
               epos_in = pnext;
            end
         end
         res_in.valid_res    = ferr_in == ERR_NONE;
         res_in.error_code   = ferr_in;
         res_in.error_offset = (ferr_in == ERR_NONE) ? '0 : OFFSET_W'(epos_in);
         lex_in = LX_IDLE; gr_in = GR_VALUE; lvl_in = '0; sub_in = 3'd0;
         ferr_in = ERR_NONE; epos_in = '0; pos_in = '0;
      end else begin
         lex_in = lx; gr_in = gr; lvl_in = lvl; sub_in = sub; pos_in = pnext;
      end

      if (!fire) begin
         lex_in = lex_ff; gr_in = gr_ff; lvl_in = lvl_ff; sub_in = sub_ff;
         ferr_in = ferr_ff; epos_in = epos_ff; pos_in = pos_ff;
         res_in = res_ff;
         push = 1'b0; pop = 1'b0;
      end
   end

   // top of stack held in a flop, the level below prefetched from memory
   always_comb begin
      top_in = top_ff;
      if (push) top_in = push_kind;
      else if (pop) top_in = below_ff;
      waddr = ADDR_W'(lvl_ff);
      raddr = ADDR_W'(lvl_in - LVL_W'(2));
      rsp_valid_in = rsp_valid_ff;
      if (fire && item.last) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[waddr] <= push_kind;
      end
      below_ff <= stack_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff       <= LX_IDLE;
         gr_ff        <= GR_VALUE;
         lvl_ff       <= '0;
         sub_ff       <= 3'd0;
         ferr_ff      <= ERR_NONE;
         epos_ff      <= '0;
         pos_ff       <= '0;
         top_ff       <= 1'b0;
         max_depth_ff <= MAX_DEPTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         lex_ff       <= lex_in;
         gr_ff        <= gr_in;
         lvl_ff       <= lvl_in;
         sub_ff       <= sub_in;
         ferr_ff      <= ferr_in;
         epos_ff      <= epos_in;
         pos_ff       <= pos_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) max_depth_ff <= csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.valid_res    = res_ff.valid_res;
   assign rsp_bus.error_code   = res_ff.error_code;
   assign rsp_bus.error_offset = res_ff.error_offset;

endmodule

// ===== hdl/json_syntax_validator.sv =====
// JSON syntax validator: one 16-bit character word is taken per clock unless a
// word marked last is held back, and one verdict word (valid flag, error code,
// offset of the first error) is presented once the word marked last has passed
// the queue and the verdict register, or later when an earlier verdict is still
// waiting on the output. A two-entry queue parts the classifying front end from
// the lexer/grammar back end, and the verdict sits in an output register, so
// words not marked last keep flowing while a verdict waits; a word marked last
// is held in the queue until the output register is free.
// Open containers are kept on a one-bit-per-level stack in memory; the top kind
// lives in a flop and the level below it is prefetched each cycle, so closing
// brackets can follow one another at full rate. The user must write the depth
// limit register through the csr channel while the block is idle (not enforced).
// ----------------------------------------------------------------------------
// json_syntax_validator
// Top level: character front end, queue and validation back end.
// ----------------------------------------------------------------------------
module json_syntax_validator
   import jsv_pkg::*;
#(
   parameter int STACK_DEPTH   = 1024,
   parameter int POSITION_BITS = 24
)
(
   input  logic      clock,
   input  logic      reset,
   jsv_req_if.sink   req_bus,
   jsv_rsp_if.source rsp_bus,
   jsv_csr_if.sink   csr_bus
);

   logic     item_valid;
   item_type item;
   logic     item_pop;

   jsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   jsv_back #(
      .STACK_DEPTH   (STACK_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule
